FILE: design/q2e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types and constants of the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

	localparam int VEC_W = 40;
	localparam int ANG_W = 32;
	localparam int ATAN_LEN = 24;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 32'sh4000_0000;
	localparam logic [15:0] GAIN_COMP = 16'd39797;
	localparam logic [15:0] PITCH_POS = 16'h4000;
	localparam logic [15:0] PITCH_NEG = 16'hC000;

	typedef logic [ATAN_LEN-1:0][ANG_W-1:0] atan_tab_t;

	localparam atan_tab_t ATAN_TAB = {
		32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
		32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
		32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
		32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
		32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
		32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
	};

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] a;
	} vec_t;

endpackage

FILE: design/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q2.14 quaternion to roll, pitch and yaw binary angles and a gimbal-lock flag.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while the sink keeps up. A word's result passes
// through two rows of CORDIC cells in series (roll and its length first, then pitch
// from that length) plus product and rounding registers. An output skid register
// holds one result while the sink stalls, and the input waits only while that register
// is full.
module quaternion_to_euler_angles #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle
	output logic        m_tuser    // gimbal_lock
);
	import q2e_pkg::*;

	localparam int LAT = 2 * CORDIC_STAGES + 6;
	localparam int A1 = CORDIC_STAGES + 1;
	localparam int DL = CORDIC_STAGES + 3;

	logic [15:0] thr_q;
	logic [LAT-1:0] vld_q;
	logic en;

	logic signed [15:0] qx, qy, qz, qw;
	logic signed [VEC_W-1:0] sx_s1, sy_s1, ys_s1, xz_s1, t_s1, ly_s1, lx_s1;
	logic signed [VEC_W-1:0] cx_s2, sx_s2, yy_s2, yx_s2, ly_s2, lx_s2, sy_s2;
	logic signed [ANG_W-1:0] roll_a, yaw_a, lock_a, pitch_a;
	logic signed [VEC_W-1:0] mag, dmag1, dmag2, dmag3;
	logic signed [VEC_W-1:0] sy_d [A1];
	logic signed [VEC_W-1:0] cy_s4, sy_s3, sy_s4;
	logic signed [57:0] prod_s3;
	logic signed [ANG_W-1:0] roll_d [DL];
	logic signed [ANG_W-1:0] yaw_d [DL];
	logic signed [ANG_W-1:0] lock_d [DL];
	logic [CORDIC_STAGES:0] lk_q, sp_q;
	logic lk_s4;
	logic [15:0] roll_o, pitch_o, yaw_o;
	logic lock_o;
	logic [48:0] result;
	logic [48:0] skid_q;
	logic skid_v_q, out_v_q;
	logic [48:0] out_q;

	assign qx = s_tdata[15:0];
	assign qy = s_tdata[31:16];
	assign qz = s_tdata[47:32];
	assign qw = s_tdata[63:48];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd7;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// The pipeline advances whenever the skid register is free.
	assign en = !skid_v_q;
	assign s_tready = en;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= VEC_W'(2 * (34'(qx * qw) - 34'(qy * qz)));
			sy_s1 <= VEC_W'(2 * (34'(qy * qw) + 34'(qx * qz)));
			ys_s1 <= VEC_W'(34'(qw * qw) - 34'(qy * qy));
			xz_s1 <= VEC_W'(34'(qx * qx) - 34'(qz * qz));
			t_s1 <= VEC_W'(2 * (34'(qz * qw) - 34'(qx * qy)));
			if (VEC_W'(2 * (34'(qy * qw) + 34'(qx * qz))) > 0) begin
				ly_s1 <= VEC_W'(qz) + VEC_W'(qx);
				lx_s1 <= VEC_W'(qw) + VEC_W'(qy);
			end else begin
				ly_s1 <= VEC_W'(qz) - VEC_W'(qx);
				lx_s1 <= VEC_W'(qw) - VEC_W'(qy);
			end
			cx_s2 <= ys_s1 - xz_s1;
			sx_s2 <= sx_s1;
			yy_s2 <= t_s1;
			yx_s2 <= ys_s1 + xz_s1;
			ly_s2 <= ly_s1;
			lx_s2 <= lx_s1;
			sy_s2 <= sy_s1;
		end
	end

	q2e_chain #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(en), .vy(sx_s2), .vx(cx_s2), .ang(roll_a), .mag(mag)
	);
	q2e_chain #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .en(en), .vy(yy_s2), .vx(yx_s2), .ang(yaw_a), .mag(dmag1)
	);
	q2e_chain #(.STAGES(CORDIC_STAGES)) u_lock (
		.clk(clk), .en(en), .vy(ly_s2), .vx(lx_s2), .ang(lock_a), .mag(dmag2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sy_d[0] <= sy_s2;
			for (int i = 1; i < A1; i++) begin
				sy_d[i] <= sy_d[i-1];
			end
			prod_s3 <= 58'(mag) * $signed({1'b0, GAIN_COMP});
			sy_s3 <= sy_d[A1-1];
			cy_s4 <= VEC_W'((prod_s3 + 58'sd32768) >>> 16);
			sy_s4 <= sy_s3;
			lk_s4 <= !(VEC_W'((prod_s3 + 58'sd32768) >>> 16) >
				$signed({24'd0, thr_q} << 14));
			roll_d[0] <= roll_a;
			yaw_d[0] <= yaw_a;
			lock_d[0] <= lock_a;
			for (int i = 1; i < DL; i++) begin
				roll_d[i] <= roll_d[i-1];
				yaw_d[i] <= yaw_d[i-1];
				lock_d[i] <= lock_d[i-1];
			end
			lk_q[0] <= lk_s4;
			sp_q[0] <= sy_s4 > 0;
			for (int i = 1; i <= CORDIC_STAGES; i++) begin
				lk_q[i] <= lk_q[i-1];
				sp_q[i] <= sp_q[i-1];
			end
		end
	end

	q2e_chain #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(en), .vy(sy_s4), .vx(cy_s4), .ang(pitch_a), .mag(dmag3)
	);

	always_comb begin
		roll_o = 16'((roll_d[DL-1] + 32'sd32768) >>> 16);
		pitch_o = 16'((pitch_a + 32'sd32768) >>> 16);
		yaw_o = 16'((yaw_d[DL-1] + 32'sd32768) >>> 16);
		lock_o = lk_q[CORDIC_STAGES];
		if (lock_o) begin
			roll_o = '0;
			pitch_o = sp_q[CORDIC_STAGES] ? PITCH_POS : PITCH_NEG;
			yaw_o = 16'(((lock_d[DL-1] <<< 1) + 32'sd32768) >>> 16);
		end
	end

	assign result = {lock_o, yaw_o, pitch_o, roll_o};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[LAT-2:0], s_tvalid && s_tready};
			end
			if (!out_v_q || m_tready) begin
				out_v_q <= skid_v_q || (en && vld_q[LAT-1]);
				skid_v_q <= 1'b0;
			end else if (en && vld_q[LAT-1]) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= result;
			end
		end else if (en && vld_q[LAT-1]) begin
			skid_q <= result;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q[47:0];
	assign m_tuser = out_q[48];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser));
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q);
	a_lock_roll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h0000);
	a_lock_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[31:16] == PITCH_POS) || (m_tdata[31:16] == PITCH_NEG));

endmodule

FILE: design/q2e_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_cell
// One registered CORDIC vectoring micro-rotation.
// ----------------------------------------------------------------------------
module q2e_cell #(
	parameter int SHIFT = 0
) (
	input  logic            clk,
	input  logic            en,
	input  q2e_pkg::vec_t   din,
	output q2e_pkg::vec_t   dout
);
	import q2e_pkg::*;

	vec_t nxt;
	logic signed [VEC_W-1:0] xs, ys;

	always_comb begin
		xs = din.x >>> SHIFT;
		ys = din.y >>> SHIFT;
		if (!din.y[VEC_W-1]) begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.a = din.a + ATAN_TAB[SHIFT];
		end else begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.a = din.a - ATAN_TAB[SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

FILE: design/q2e_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_chain
// Pre-rotation followed by a row of CORDIC cells; gives angle and raw length.
// ----------------------------------------------------------------------------
module q2e_chain #(
	parameter int STAGES = 16
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [q2e_pkg::VEC_W-1:0]      vy,
	input  logic signed [q2e_pkg::VEC_W-1:0]      vx,
	output logic signed [q2e_pkg::ANG_W-1:0]      ang,
	output logic signed [q2e_pkg::VEC_W-1:0]      mag
);
	import q2e_pkg::*;

	vec_t pre;
	vec_t pre_s1;
	vec_t link [STAGES+1];
	logic zero_s1;
	logic [STAGES-1:0] zero_q;

	always_comb begin
		pre.x = vx;
		pre.y = vy;
		pre.a = '0;
		if (vx[VEC_W-1]) begin
			if (!vy[VEC_W-1]) begin
				pre.x = vy;
				pre.y = -vx;
				pre.a = QUARTER_TURN;
			end else begin
				pre.x = -vy;
				pre.y = vx;
				pre.a = -QUARTER_TURN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= pre;
			zero_s1 <= (vx == '0) && (vy == '0);
			zero_q <= {zero_q[STAGES-2:0], zero_s1};
		end
	end

	assign link[0] = pre_s1;

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		q2e_cell #(.SHIFT(i)) u_cell (
			.clk(clk), .en(en), .din(link[i]), .dout(link[i+1])
		);
	end

	assign ang = zero_q[STAGES-1] ? '0 : link[STAGES].a;
	assign mag = zero_q[STAGES-1] ? '0 : link[STAGES].x;

endmodule
